// ----- sv/round_trip_time_statistics_macros.svh -----
// Assertion macros for round_trip_time_statistics
`ifndef ROUND_TRIP_TIME_STATISTICS_MACROS_SVH
`define ROUND_TRIP_TIME_STATISTICS_MACROS_SVH
`ifndef SYNTHESIS
`define RTS_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("rts assertion failed");
`define RTS_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("rts assertion failed");
`else
`define RTS_ASSERT_IMPL(label, a, c)
`define RTS_ASSERT_NEXT(label, a, c)
`endif
`endif

// ----- sv/rts_pkg.sv -----
// ----------------------------------------------------------------------------
// rts_pkg
// Types and constants for the round-trip time statistics block.
// ----------------------------------------------------------------------------
package rts_pkg;
    localparam int RTT_BITS   = 20;
    localparam int COUNT_BITS = 20;
    localparam int FIELD_BITS = 20;
    localparam int SUM_BITS   = RTT_BITS + COUNT_BITS;
    localparam int SQ_BITS    = 2 * RTT_BITS + COUNT_BITS;
    localparam int ROOT_BITS  = (SQ_BITS + 1) / 2;

    typedef struct packed {
        logic                req_type;
        logic [FIELD_BITS-1:0] rtt_us;
    } rts_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] sent_total;
        logic [FIELD_BITS-1:0] received_total;
        logic [FIELD_BITS-1:0] rtt_min;
        logic [FIELD_BITS-1:0] rtt_max;
        logic [FIELD_BITS-1:0] rtt_mean;
        logic [FIELD_BITS-1:0] rtt_deviation;
        logic                  saturated;
    } rts_out_t;

    // Snapshot handed from the front part to the back part.
    typedef struct packed {
        logic [COUNT_BITS-1:0] sent;
        logic [COUNT_BITS-1:0] recv;
        logic [RTT_BITS-1:0]   min_v;
        logic [RTT_BITS-1:0]   max_v;
        logic [SUM_BITS-1:0]   sum;
        logic [SQ_BITS-1:0]    sq;
        logic                  sat;
    } rts_job_t;
endpackage

// ----- sv/rts_front.sv -----
// ----------------------------------------------------------------------------
// rts_front
// Accepts events, updates counts, extremes and sums, emits snapshots.
// ----------------------------------------------------------------------------
module rts_front
    import rts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  rts_in_t  in_data,
    output logic     job_valid,
    input  logic     job_ready,
    output rts_job_t job
);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] sent_reg, recv_reg;
    logic [RTT_BITS-1:0]   min_reg, max_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SQ_BITS-1:0]    sq_reg;
    logic                  sq_busy_reg;
    logic [RTT_BITS-1:0]   rtt_reg;
    logic [2*RTT_BITS-1:0] prod;
    logic                  sat_reg;
    logic                  jv_reg;
    logic [RTT_BITS-1:0]   rtt;
    logic                  accept;

    assign rtt    = in_data.rtt_us[RTT_BITS-1:0];
    assign full   = jv_reg || sq_busy_reg;
    assign accept = push && !full;
    assign prod   = rtt_reg * rtt_reg;

    assign job_valid = jv_reg;
    assign job.sent  = sent_reg;
    assign job.recv  = recv_reg;
    assign job.min_v = min_reg;
    assign job.max_v = max_reg;
    assign job.sum   = sum_reg;
    assign job.sq    = sq_reg;
    assign job.sat   = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= '0; recv_reg <= '0; min_reg <= '0; max_reg <= '0;
            sum_reg <= '0; sq_reg <= '0; sq_busy_reg <= 1'b0; rtt_reg <= '0;
            sat_reg <= 1'b0; jv_reg <= 1'b0;
        end
        else
        begin
            if (job_valid && job_ready)
                jv_reg <= 1'b0;
            if (sq_busy_reg)
            begin
                sq_reg      <= sq_reg + SQ_BITS'(prod);
                sq_busy_reg <= 1'b0;
                jv_reg      <= 1'b1;
            end
            else if (accept)
            begin
                sat_reg <= 1'b0;
                if (!in_data.req_type)
                begin
                    if (sent_reg != CMAX)
                        sent_reg <= sent_reg + 1'b1;
                    jv_reg <= 1'b1;
                end
                else if (recv_reg == CMAX)
                begin
                    sat_reg <= 1'b1;
                    jv_reg  <= 1'b1;
                end
                else
                begin
                    if (recv_reg == '0 || rtt < min_reg)
                        min_reg <= rtt;
                    if (recv_reg == '0 || rtt > max_reg)
                        max_reg <= rtt;
                    sum_reg     <= sum_reg + SUM_BITS'(rtt);
                    recv_reg    <= recv_reg + 1'b1;
                    rtt_reg     <= rtt;
                    sq_busy_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- sv/rts_back.sv -----
// ----------------------------------------------------------------------------
// rts_back
// Iterative divisions and square root; holds one result for the consumer.
// ----------------------------------------------------------------------------
`include "round_trip_time_statistics_macros.svh"
module rts_back
    import rts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  rts_job_t job,
    output logic     empty,
    input  logic     pop,
    output rts_out_t out_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_MSQ  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam int CNT_W = $clog2(SQ_BITS + 1);

    logic [2:0]            state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    rts_job_t              job_reg;
    logic [SQ_BITS-1:0]    quo_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [RTT_BITS-1:0]   mean_reg;
    logic [SQ_BITS-1:0]    var_reg;
    logic [ROOT_BITS-1:0]  root_reg;
    logic [ROOT_BITS+1:0]  srem_reg;
    logic                  full_reg;
    rts_out_t              res_reg;

    logic [COUNT_BITS:0]   rem_sh, rem_sub;
    logic [ROOT_BITS+1:0]  s_sh, s_try;
    logic                  s_ok;
    logic [2*RTT_BITS-1:0] msq_prod;

    assign job_ready = (state_reg == S_IDLE);
    assign empty     = !full_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        rem_sh  = {rem_reg[COUNT_BITS-1:0], quo_reg[SQ_BITS-1]};
        rem_sub = rem_sh - {1'b0, job_reg.recv};
        s_sh    = {srem_reg[ROOT_BITS-1:0], var_reg[SQ_BITS-1 -: 2]};
        s_try   = {root_reg, 2'b01};
        s_ok    = s_sh >= s_try;
        msq_prod = mean_reg * mean_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; cnt_reg <= '0; full_reg <= 1'b0;
            job_reg <= '0; quo_reg <= '0; rem_reg <= '0; mean_reg <= '0;
            var_reg <= '0; root_reg <= '0; srem_reg <= '0; res_reg <= '0;
        end
        else
        begin
            if (pop && full_reg && state_reg != S_DONE)
                full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        quo_reg <= SQ_BITS'(job.sum);
                        rem_reg <= '0;
                        cnt_reg <= CNT_W'(SQ_BITS);
                        state_reg <= (job.recv == '0) ? S_DONE : S_DIV1;
                        mean_reg <= '0;
                        root_reg <= '0;
                    end
                end
                S_DIV1, S_DIV2:
                begin
                    if (!rem_sub[COUNT_BITS])
                    begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[SQ_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[SQ_BITS-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= (state_reg == S_DIV1) ? S_MSQ : S_MUL;
                end
                S_MSQ:
                begin
                    mean_reg  <= quo_reg[RTT_BITS-1:0];
                    quo_reg   <= job_reg.sq;
                    rem_reg   <= '0;
                    cnt_reg   <= CNT_W'(SQ_BITS);
                    state_reg <= S_DIV2;
                end
                S_MUL:
                begin
                    var_reg <= (quo_reg > SQ_BITS'(msq_prod))
                        ? (quo_reg - SQ_BITS'(msq_prod)) : '0;
                    srem_reg  <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= CNT_W'(ROOT_BITS);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    var_reg <= {var_reg[SQ_BITS-3:0], 2'b00};
                    if (s_ok)
                    begin
                        srem_reg <= s_sh - s_try;
                        root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= s_sh;
                        root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!full_reg || pop)
                    begin
                        res_reg.sent_total     <= FIELD_BITS'(job_reg.sent);
                        res_reg.received_total <= FIELD_BITS'(job_reg.recv);
                        res_reg.rtt_min  <= (job_reg.recv != '0) ? FIELD_BITS'(job_reg.min_v) : '0;
                        res_reg.rtt_max  <= (job_reg.recv != '0) ? FIELD_BITS'(job_reg.max_v) : '0;
                        res_reg.rtt_mean      <= FIELD_BITS'(mean_reg);
                        res_reg.rtt_deviation <= FIELD_BITS'(root_reg);
                        res_reg.saturated     <= job_reg.sat;
                        full_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `RTS_ASSERT_IMPL(a_take_idle, job_valid && job_ready, state_reg == S_IDLE)
    `RTS_ASSERT_NEXT(a_done_fill, state_reg == S_DONE && (!full_reg || pop), full_reg)
    `RTS_ASSERT_IMPL(a_sat_recv, full_reg && res_reg.saturated,
                     res_reg.received_total == {FIELD_BITS{1'b1}})
endmodule

// ----- sv/round_trip_time_statistics.sv -----
// ----------------------------------------------------------------------------
// round_trip_time_statistics
// Ping round-trip statistics: counts, min, max, mean and deviation.
// ----------------------------------------------------------------------------
// channel  | handshake    | payload
// input    | push / full  | in_data  (rts_in_t)
// result   | empty / pop  | out_data (rts_out_t)
// A transmit before any receive skips the back part's arithmetic; any other event
// goes through two 60-step restoring divisions and a 30-step square root in the back part.
// One item is in the back part while the front part holds the next one.
// Reset clears all statistics; no clearing pass.
// A stalled result holds the back part; full rises behind it.
module round_trip_time_statistics
    import rts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  rts_in_t  in_data,
    output logic     empty,
    input  logic     pop,
    output rts_out_t out_data
);
    logic     job_valid, job_ready;
    rts_job_t job;

    rts_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    rts_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
        .job(job), .empty(empty), .pop(pop), .out_data(out_data)
    );
endmodule

// ----- verif/round_trip_time_statistics_checker.sv -----
// ----------------------------------------------------------------------------
// round_trip_time_statistics_checker
// Watches both channels of the round-trip statistics block, keeps its own
// running statistics for every accepted input transfer and compares each
// result transfer field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module round_trip_time_statistics_checker
    import rts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  rts_in_t  in_data,
    input  logic     empty,
    input  logic     pop,
    input  rts_out_t out_data,
    output int       fail_count,
    output int       pending_count,
    output int       sat_seen
);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    logic [COUNT_BITS-1:0] sent_cnt;
    logic [COUNT_BITS-1:0] recv_cnt;
    logic [RTT_BITS-1:0]   low_rtt;
    logic [RTT_BITS-1:0]   high_rtt;
    logic [63:0]           rtt_total;
    logic [63:0]           rtt_sq_total;
    rts_out_t              expected_stats[$];

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic account_event(input rts_in_t ev);
        rts_out_t    r;
        logic [63:0] rtt;
        logic [63:0] mean;
        logic [63:0] msq;
        logic [63:0] var_v;
        logic [63:0] root_v;
        rtt = 64'(ev.rtt_us[RTT_BITS-1:0]);
        r = '0;
        if (!ev.req_type)
        begin
            if (sent_cnt != COUNT_TOP)
                sent_cnt = sent_cnt + 1'b1;
        end
        else if (recv_cnt == COUNT_TOP)
            r.saturated = 1'b1;
        else
        begin
            if (recv_cnt == 0)
            begin
                low_rtt = rtt[RTT_BITS-1:0];
                high_rtt = rtt[RTT_BITS-1:0];
            end
            else
            begin
                if (rtt < low_rtt)
                    low_rtt = rtt[RTT_BITS-1:0];
                if (rtt > high_rtt)
                    high_rtt = rtt[RTT_BITS-1:0];
            end
            rtt_total = rtt_total + rtt;
            rtt_sq_total = rtt_sq_total + rtt * rtt;
            recv_cnt = recv_cnt + 1'b1;
        end
        r.sent_total = sent_cnt;
        r.received_total = recv_cnt;
        if (recv_cnt != 0)
        begin
            mean = rtt_total / recv_cnt;
            msq = rtt_sq_total / recv_cnt;
            var_v = (msq > mean * mean) ? msq - mean * mean : 0;
            root_v = floor_root(var_v);
            r.rtt_min = low_rtt;
            r.rtt_max = high_rtt;
            r.rtt_mean = mean[FIELD_BITS-1:0];
            r.rtt_deviation = root_v[FIELD_BITS-1:0];
        end
        expected_stats.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [FIELD_BITS-1:0] exp_v,
                                 input logic [FIELD_BITS-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rts_out_t e;
        if (!rst_n)
        begin
            sent_cnt = '0;
            recv_cnt = '0;
            low_rtt = '0;
            high_rtt = '0;
            rtt_total = '0;
            rtt_sq_total = '0;
            expected_stats.delete();
            fail_count = 0;
            sat_seen = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("result transfer with no expected result");
                    fail_count++;
                end
                else
                begin
                    e = expected_stats.pop_front();
                    compare_field("sent_total", e.sent_total, out_data.sent_total);
                    compare_field("received_total", e.received_total,
                                  out_data.received_total);
                    compare_field("rtt_min", e.rtt_min, out_data.rtt_min);
                    compare_field("rtt_max", e.rtt_max, out_data.rtt_max);
                    compare_field("rtt_mean", e.rtt_mean, out_data.rtt_mean);
                    compare_field("rtt_deviation", e.rtt_deviation,
                                  out_data.rtt_deviation);
                    compare_field("saturated", FIELD_BITS'(e.saturated),
                                  FIELD_BITS'(out_data.saturated));
                    if (e.saturated)
                        sat_seen++;
                end
            end
            if (push && !full)
                account_event(in_data);
        end
        pending_count = expected_stats.size();
    end
endmodule

// ----- verif/round_trip_time_statistics_test.sv -----
// ----------------------------------------------------------------------------
// round_trip_time_statistics_test
// Drives transmit and receive events into the round-trip statistics block
// with bursty input and a stalling consumer; a checker predicts every result.
// ----------------------------------------------------------------------------
module round_trip_time_statistics_test;
    import rts_pkg::*;

    localparam logic REQ_TX = 1'b0;
    localparam logic REQ_RX = 1'b1;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    rts_in_t  in_data;
    logic     empty;
    logic     pop;
    rts_out_t out_data;
    int       fail_count;
    int       pending_count;
    int       sat_seen;
    int       rx_sent;
    bit       hold_off;

    round_trip_time_statistics dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    round_trip_time_statistics_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_data       (in_data),
        .empty         (empty),
        .pop           (pop),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .sat_seen      (sat_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_event(input logic kind, input logic [FIELD_BITS-1:0] rtt);
        push <= 1'b1;
        in_data <= '{req_type: kind, rtt_us: rtt};
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (kind == REQ_RX)
            rx_sent++;
    endtask

    task automatic idle_gap(input int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [FIELD_BITS-1:0] random_rtt();
        case ($urandom_range(0, 5))
            0: return FIELD_BITS'($urandom_range(0, 255));
            1: return '1 - FIELD_BITS'($urandom_range(0, 255));
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off
    initial
    begin
        int mode;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                pop <= 1'b0;
                repeat (2000) @(posedge clk);
                hold_off = 1'b0;
            end
            mode = ($urandom_range(0, 199) < 4) ? 1 : 0;
            if (mode == 1)
                pop <= ($urandom_range(0, 3) == 0);
            else
                pop <= ($urandom_range(0, 9) < 7);
        end
    end

    initial
    begin
        int burst;
        rst_n = 1'b0;
        push = 1'b0;
        in_data = '0;
        rx_sent = 0;
        hold_off = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(REQ_TX, '0);
        send_event(REQ_RX, '0);
        send_event(REQ_RX, '1);
        send_event(REQ_RX, 20'h55555);
        send_event(REQ_RX, 20'hAAAAA);
        send_event(REQ_TX, '1);
        send_event(REQ_RX, 20'd1);
        send_event(REQ_RX, 20'hFFFFE);
        send_event(REQ_RX, 20'd1000);
        send_event(REQ_TX, 20'd7);
        wait_drained();

        hold_off = 1'b1;
        for (int i = 0; i < 40; i++)
            send_event(1'($urandom_range(0, 1)), random_rtt());
        wait_drained();

        for (int i = 0; i < 750; )
        begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst; j++, i++)
                send_event(($urandom_range(0, 2) != 0) ? REQ_RX : REQ_TX, random_rtt());
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 300));
        end
        wait_drained();

        $display("Ran about 800 transmit/receive events (%0d receives) with bursts,",
                 rx_sent);
        $display("consumer stalls and one long output hold-off; %0d saturated results.",
                 sat_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/rts_pkg.sv
sv/rts_front.sv
sv/rts_back.sv
sv/round_trip_time_statistics.sv
verif/round_trip_time_statistics_checker.sv
verif/round_trip_time_statistics_test.sv
